// ===== src/int8_matrix_multiply_accumulate_top_assert.svh =====
// Assertion macros for the int8 matrix multiply-accumulate block.
`ifndef INT8_MATRIX_MULTIPLY_ACCUMULATE_TOP_ASSERT_SVH
`define INT8_MATRIX_MULTIPLY_ACCUMULATE_TOP_ASSERT_SVH

`ifndef SYNTH
// Checked on every rising clock edge, suspended while reset is high.
`define I8MMA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("i8mma assertion failed");
// Checked on every rising clock edge, reset included.
`define I8MMA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("i8mma assertion failed");
`else
`define I8MMA_ASSERT(label, clk, rst, prop)
`define I8MMA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== src/i8mma_pkg.sv =====
// Types, constants and address helpers shared by the matrix multiply-accumulate block.
package i8mma_pkg;

   localparam int ROWS      = 16;
   localparam int COLS      = 16;
   localparam int MAX_DEPTH = 64;

   localparam int IDX_W   = 6;
   localparam int VALUE_W = 32;
   localparam int KSIZE_W = 7;
   localparam int ELEM_W  = 8;
   localparam int PROD_W  = 2 * ELEM_W;

   localparam int A_DEPTH = ROWS * MAX_DEPTH;
   localparam int B_DEPTH = MAX_DEPTH * COLS;
   localparam int C_DEPTH = ROWS * COLS;
   localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
   localparam int C_AW    = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

   // Inner index width, and a counter width that can also hold MAX_DEPTH.
   localparam int K_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int DEPTH_CW = $clog2(MAX_DEPTH + 1);

   localparam logic [KSIZE_W-1:0] KSIZE_RESET = KSIZE_W'(64);

   localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
   localparam logic [1:0] FUNC_LOAD_C  = 2'd2;
   localparam logic [1:0] FUNC_COMPUTE = 2'd3;

   typedef struct packed {
      logic [1:0]               func;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic [IDX_W-1:0]          out_row;
      logic [IDX_W-1:0]          out_col;
      logic                      index_error;
   } rsp_type;

   typedef struct packed {
      logic load_acc;
      logic mul_en;
   } mac_ctl_type;

   function automatic logic [A_AW-1:0] a_addr(input logic [IDX_W-1:0] row,
                                              input logic [IDX_W-1:0] k);
      return A_AW'(A_AW'(row) * A_AW'(MAX_DEPTH)) + A_AW'(k);
   endfunction

   function automatic logic [B_AW-1:0] b_addr(input logic [IDX_W-1:0] k,
                                              input logic [IDX_W-1:0] col);
      return B_AW'(B_AW'(k) * B_AW'(COLS)) + B_AW'(col);
   endfunction

   function automatic logic [C_AW-1:0] c_addr(input logic [IDX_W-1:0] row,
                                              input logic [IDX_W-1:0] col);
      return C_AW'(C_AW'(row) * C_AW'(COLS)) + C_AW'(col);
   endfunction

endpackage

// ===== src/i8mma_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module i8mma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/i8mma_mac.sv =====
// Shared multiply-accumulate unit: one registered 8x8 product and a 32-bit accumulator.
module i8mma_mac
   import i8mma_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  mac_ctl_type         ctl,
   input  logic [VALUE_W-1:0]  acc_init,
   input  logic [ELEM_W-1:0]   a_elem,
   input  logic [ELEM_W-1:0]   b_elem,
   output logic                busy,
   output logic [VALUE_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_vld_ff;
   logic [VALUE_W-1:0]       acc_ff;
   logic [VALUE_W-1:0]       acc_in;

   always_comb begin
      prod_in = $signed(a_elem) * $signed(b_elem);
      acc_in  = acc_ff;
      if (ctl.load_acc) begin
         acc_in = acc_init;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + {{(VALUE_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign busy = prod_vld_ff;
   assign acc  = acc_ff;

endmodule

// ===== src/int8_matrix_multiply_accumulate_top.sv =====
// Top level of the int8 matrix multiply-accumulate block with its sequencer.
//
// This block keeps A (ROWS x MAX_DEPTH int8), B (MAX_DEPTH x COLS int8) and the
// int32 accumulators C (ROWS x COLS) in three RAMs and computes one output element
// per compute request: C[row][col] plus the sum over k < min(k_size, MAX_DEPTH) of
// A[row][k]*B[k][col], wrapping at 32 bits, written back to C and returned on the
// response channel. Load requests (func 0, 1, 2) are written at acceptance and give
// no response; a load outside its store is dropped. A compute request walks the inner
// dimension with a single shared multiply-accumulate unit, one pair per cycle, and no
// new request is taken until it is through: one issue per pair, then the registered
// RAM read, the product register, the drain check, the write-back state and the idle
// state that takes the next request. A compute request with row or column outside C
// gives index_error with a zero value and leaves the stores alone; it goes straight
// to the write-back state, which registers its response and returns to idle to take
// the next request. The block accepts requests only while its sequencer is idle; a
// finished response waits in an output register, so loads keep flowing while it is
// unclaimed, and a compute result waits for that register to drain. The stores are not
// cleared by reset: every entry must be loaded before a compute reads it. The k_size
// register resets to 64 and is written through csr_wr_en and csr_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
`include "int8_matrix_multiply_accumulate_top_assert.svh"
module int8_matrix_multiply_accumulate_top
   import i8mma_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_payload,
   input  logic               csr_wr_en,
   input  logic [KSIZE_W-1:0] csr_wr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [KSIZE_W-1:0]  k_size_ff;
   logic [DEPTH_CW-1:0] depth_ff, depth_in;
   logic [DEPTH_CW-1:0] k_ff, k_in;
   logic [IDX_W-1:0]    row_ff, row_in;
   logic [IDX_W-1:0]    col_ff, col_in;
   logic                err_ff, err_in;
   logic                first_ff, first_in;
   logic                c_vld_ff, ab_vld_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic        accept;
   logic        in_range_c;
   logic        ab_rd;
   logic        c_rd;
   logic        done;
   logic        rsp_free;
   logic        a_wr_en, b_wr_en, c_wr_en;
   logic [C_AW-1:0]    c_wr_addr;
   logic [VALUE_W-1:0] c_wr_data;
   logic [ELEM_W-1:0]  a_rd_data, b_rd_data;
   logic [VALUE_W-1:0] c_rd_data;
   logic [IDX_W-1:0]   k_idx;
   logic [VALUE_W-1:0] acc;
   logic               mac_busy;
   mac_ctl_type        mac_ctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign k_idx     = IDX_W'(k_ff[K_W-1:0]);

   assign in_range_c = (int'(req_payload.row) < ROWS) && (int'(req_payload.col) < COLS);

   // Loads write straight into their store at acceptance.
   assign a_wr_en = accept && (req_payload.func == FUNC_LOAD_A)
                    && (int'(req_payload.row) < ROWS) && (int'(req_payload.col) < MAX_DEPTH);
   assign b_wr_en = accept && (req_payload.func == FUNC_LOAD_B)
                    && (int'(req_payload.row) < MAX_DEPTH) && (int'(req_payload.col) < COLS);

   // The accumulator store is written by a C load or by the write-back of a compute.
   always_comb begin
      c_wr_en   = 1'b0;
      c_wr_addr = c_addr(req_payload.row, req_payload.col);
      c_wr_data = req_payload.value;
      if (state_ff == ST_FINISH) begin
         c_wr_en   = rsp_free && !err_ff;
         c_wr_addr = c_addr(row_ff, col_ff);
         c_wr_data = acc;
      end else if (accept && (req_payload.func == FUNC_LOAD_C) && in_range_c) begin
         c_wr_en = 1'b1;
      end
   end

   // The accumulator is read once at the start of a compute; A and B pairs are read
   // alongside it and after, one per cycle, until the inner index reaches the depth.
   assign c_rd  = (state_ff == ST_RUN) && first_ff;
   assign ab_rd = (state_ff == ST_RUN) && (k_ff < depth_ff);
   assign done  = (state_ff == ST_RUN) && !first_ff && !ab_rd
                  && !c_vld_ff && !ab_vld_ff && !mac_busy;

   assign mac_ctl.load_acc = c_vld_ff;
   assign mac_ctl.mul_en   = ab_vld_ff;

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      k_in         = k_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      err_in       = err_ff;
      first_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      // Inner length above the store depth saturates.
      if (int'(k_size_ff) > MAX_DEPTH) begin
         depth_in = DEPTH_CW'(MAX_DEPTH);
      end else begin
         depth_in = DEPTH_CW'(k_size_ff);
      end
      if (!accept) begin
         depth_in = depth_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_payload.func == FUNC_COMPUTE)) begin
               row_in = req_payload.row;
               col_in = req_payload.col;
               k_in   = '0;
               err_in = !in_range_c;
               if (in_range_c) begin
                  first_in = 1'b1;
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_RUN: begin
            if (ab_rd) begin
               k_in = k_ff + DEPTH_CW'(1);
            end
            if (done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.out_row      = row_ff;
               rsp_in.out_col      = col_ff;
               rsp_in.index_error  = err_ff;
               rsp_in.result_value = err_ff ? '0 : $signed(acc);
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_size_ff    <= KSIZE_RESET;
         first_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         ab_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         c_vld_ff     <= c_rd;
         ab_vld_ff    <= ab_rd;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            k_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      depth_ff <= depth_in;
      k_ff     <= k_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      err_ff   <= err_in;
      rsp_ff   <= rsp_in;
   end

   i8mma_ram #(.WIDTH(ELEM_W), .DEPTH(A_DEPTH)) u_left_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_addr(req_payload.row, req_payload.col)),
      .wr_data (req_payload.value[ELEM_W-1:0]),
      .rd_en   (ab_rd),
      .rd_addr (a_addr(row_ff, k_idx)),
      .rd_data (a_rd_data)
   );

   i8mma_ram #(.WIDTH(ELEM_W), .DEPTH(B_DEPTH)) u_right_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_addr(req_payload.row, req_payload.col)),
      .wr_data (req_payload.value[ELEM_W-1:0]),
      .rd_en   (ab_rd),
      .rd_addr (b_addr(k_idx, col_ff)),
      .rd_data (b_rd_data)
   );

   i8mma_ram #(.WIDTH(VALUE_W), .DEPTH(C_DEPTH)) u_acc_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_en   (c_rd),
      .rd_addr (c_addr(row_ff, col_ff)),
      .rd_data (c_rd_data)
   );

   i8mma_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .acc_init (c_rd_data),
      .a_elem   (a_rd_data),
      .b_elem   (b_rd_data),
      .busy     (mac_busy),
      .acc      (acc)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A response appears only as the sequencer leaves its write-back state.
   `I8MMA_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid) |-> $past(state_ff) == ST_FINISH)
   // The inner index never runs past the saturated depth.
   `I8MMA_ASSERT(a_k_bounded, clock, reset, (state_ff == ST_RUN) |-> (k_ff <= depth_ff))
   // Outside idle, the accumulator store is written only by a good compute's write-back.
   `I8MMA_ASSERT(a_c_writeback, clock, reset, (c_wr_en && state_ff != ST_IDLE) |-> (state_ff == ST_FINISH && !err_ff))
   // Reset leaves no response pending.
   `I8MMA_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

endmodule
